// ===== design/i2cw_pkg.sv =====
// Shared types and constants for the I2C master write engine.
// No dependencies; every other design file refers to it by scoped names.
package i2cw_pkg;

  localparam int HALF_PERIOD_BITS          = 10;
  localparam int WAIT_COUNTER_BITS_DEFAULT = 10;
  localparam int CFG_ADDR_BITS             = 3;
  localparam int CFG_DATA_BITS             = 32;

  localparam logic [HALF_PERIOD_BITS-1:0] HALF_PERIOD_RESET = 10'd24;

  // Register indexes on the configuration port.
  localparam logic [0:0] REG_HALF_PERIOD = 1'b0;

  // Input command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Transfer status codes.
  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_OK   = 2'd1;
  localparam logic [1:0] STATUS_NACK = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       sda_level;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       ready_res;
    logic       byte_acked;
    logic [1:0] transfer_status;
  } rsp_t;

endpackage

// ===== design/i2cw_regs.sv =====
// APB-style configuration register file holding the half-period setting.
// Depends on i2cw_pkg for widths, the reset value and register indexes.
module i2cw_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [i2cw_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [i2cw_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [i2cw_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  output logic [i2cw_pkg::HALF_PERIOD_BITS-1:0] half_period
);

  logic [0:0] reg_index;
  logic       write_en;

  // Registers sit on 32-bit word boundaries.
  assign reg_index = paddr[2:2];
  assign write_en  = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cw_pkg::HALF_PERIOD_RESET;
    end else if (write_en && (reg_index == i2cw_pkg::REG_HALF_PERIOD)) begin
      half_period <= pwdata[i2cw_pkg::HALF_PERIOD_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == i2cw_pkg::REG_HALF_PERIOD) begin
      prdata[i2cw_pkg::HALF_PERIOD_BITS-1:0] = half_period;
    end
  end

endmodule

// ===== design/i2cw_engine.sv =====
// Waveform state machine: one step per accepted item, result register behind it.
// Depends on i2cw_pkg for the command and result structs and status codes.
module i2cw_engine #(
  parameter int WAIT_COUNTER_BITS = i2cw_pkg::WAIT_COUNTER_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  i2cw_pkg::cmd_t                        cmd,
  input  logic [i2cw_pkg::HALF_PERIOD_BITS-1:0] half_period,
  input  logic                                  rsp_stall,
  output logic                                  rsp_valid,
  output i2cw_pkg::rsp_t                        rsp
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_BIT_LOW  = 4'd3,
    PH_BIT_HIGH = 4'd4,
    PH_ACK_LOW  = 4'd5,
    PH_ACK_HIGH = 4'd6,
    PH_HOLD     = 4'd7,
    PH_STOP_A   = 4'd8,
    PH_STOP_B   = 4'd9,
    PH_STOP_C   = 4'd10
  } phase_t;

  localparam int W = WAIT_COUNTER_BITS;
  localparam logic [3:0] LAST_BIT  = 4'd7;
  localparam logic [3:0] ACK_INDEX = 4'd8;

  phase_t                phase, phase_next;
  logic [3:0]            bit_index, bit_index_next;
  logic [W-1:0]          wait_count, wait_count_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic                  stop_after, stop_after_next;
  logic                  aborted, aborted_next;
  i2cw_pkg::rsp_t        rsp_next;

  logic [W+i2cw_pkg::HALF_PERIOD_BITS-1:0] half_wide;
  logic [W-1:0]          limit;
  logic [W-1:0]          wait_inc;
  logic                  still_waiting;
  logic                  acked;
  logic [1:0]            status;

  // The half period is masked to the counter width; zero behaves as one tick.
  assign half_wide = {{W{1'b0}}, half_period};
  always_comb begin
    limit = half_wide[W-1:0];
    if (limit == '0) begin
      limit = {{(W-1){1'b0}}, 1'b1};
    end
  end

  assign wait_inc      = wait_count + {{(W-1){1'b0}}, 1'b1};
  assign still_waiting = (wait_inc < limit) && (wait_inc != '0);

  always_comb begin
    phase_next      = phase;
    bit_index_next  = bit_index;
    wait_count_next = wait_count;
    shift_byte_next = shift_byte;
    stop_after_next = stop_after;
    aborted_next    = aborted;
    acked           = 1'b0;
    status          = i2cw_pkg::STATUS_NONE;

    if (cmd.command == i2cw_pkg::CMD_LOAD) begin
      // A load is taken only on an idle or held bus; a continuation byte
      // needs an open transfer that has not been aborted.
      if ((phase == PH_IDLE && cmd.first_byte) ||
          (phase == PH_HOLD && (cmd.first_byte || !aborted))) begin
        shift_byte_next = cmd.data_byte;
        stop_after_next = cmd.last_byte;
        bit_index_next  = '0;
        wait_count_next = '0;
        if (cmd.first_byte) begin
          aborted_next = 1'b0;
          phase_next   = PH_START_A;
        end else begin
          phase_next   = PH_BIT_LOW;
        end
      end
    end else if (phase != PH_IDLE && phase != PH_HOLD) begin
      if (phase > PH_STOP_C) begin
        phase_next      = PH_IDLE;
        wait_count_next = '0;
      end else if (still_waiting) begin
        wait_count_next = wait_inc;
      end else begin
        wait_count_next = '0;
        unique case (phase)
          PH_START_A: phase_next = PH_START_B;
          PH_START_B: phase_next = PH_BIT_LOW;
          PH_BIT_LOW: phase_next = PH_BIT_HIGH;
          PH_BIT_HIGH: begin
            shift_byte_next = {shift_byte[6:0], 1'b0};
            if (bit_index < LAST_BIT) begin
              bit_index_next = bit_index + 4'd1;
              phase_next     = PH_BIT_LOW;
            end else begin
              bit_index_next = ACK_INDEX;
              phase_next     = PH_ACK_LOW;
            end
          end
          PH_ACK_LOW: phase_next = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            bit_index_next = '0;
            if (!cmd.sda_level) begin
              acked      = 1'b1;
              phase_next = stop_after ? PH_STOP_A : PH_HOLD;
            end else begin
              aborted_next = 1'b1;
              phase_next   = PH_STOP_A;
            end
          end
          PH_STOP_A: phase_next = PH_STOP_B;
          PH_STOP_B: phase_next = PH_STOP_C;
          default: begin
            status          = aborted ? i2cw_pkg::STATUS_NACK : i2cw_pkg::STATUS_OK;
            stop_after_next = 1'b0;
            phase_next      = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Bus levels follow the phase the item leaves behind.
  always_comb begin
    rsp_next.byte_acked      = acked;
    rsp_next.transfer_status = status;
    rsp_next.ready_res       = (phase_next == PH_IDLE) || (phase_next == PH_HOLD);
    unique case (phase_next)
      PH_START_B:  begin rsp_next.scl_level = 1'b1; rsp_next.sda_drive = 1'b0; end
      PH_BIT_LOW:  begin rsp_next.scl_level = 1'b0; rsp_next.sda_drive = shift_byte_next[7]; end
      PH_BIT_HIGH: begin rsp_next.scl_level = 1'b1; rsp_next.sda_drive = shift_byte_next[7]; end
      PH_ACK_LOW:  begin rsp_next.scl_level = 1'b0; rsp_next.sda_drive = 1'b1; end
      PH_HOLD:     begin rsp_next.scl_level = 1'b0; rsp_next.sda_drive = 1'b1; end
      PH_STOP_A:   begin rsp_next.scl_level = 1'b0; rsp_next.sda_drive = 1'b0; end
      PH_STOP_B:   begin rsp_next.scl_level = 1'b1; rsp_next.sda_drive = 1'b0; end
      default:     begin rsp_next.scl_level = 1'b1; rsp_next.sda_drive = 1'b1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_index  <= '0;
      wait_count <= '0;
      shift_byte <= '0;
      stop_after <= 1'b0;
      aborted    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        bit_index  <= bit_index_next;
        wait_count <= wait_count_next;
        shift_byte <= shift_byte_next;
        stop_after <= stop_after_next;
        aborted    <= aborted_next;
        rsp        <= rsp_next;
        rsp_valid  <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid  <= 1'b0;
      end
    end
  end

endmodule

// ===== design/i2c_master_write_engine.sv =====
// Results are registered and show in the cycle after the item is accepted.
// Throughput: one item per cycle while no result is stalled; the result
// register frees as it is taken, so a new item is taken in the cycle the
// previous result transfers. Reset (synchronous, rst high): engine idle,
// no result pending, half period back to 24 ticks.
module i2c_master_write_engine #(
  parameter int WAIT_COUNTER_BITS = i2cw_pkg::WAIT_COUNTER_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  i2cw_pkg::cmd_t                     cmd,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output i2cw_pkg::rsp_t                     rsp,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [i2cw_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [i2cw_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [i2cw_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  logic [i2cw_pkg::HALF_PERIOD_BITS-1:0] half_period;
  logic                                  accept;

  // Stall only while a result is held and the far side is not taking it.
  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  i2cw_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .half_period (half_period)
  );

  i2cw_engine #(
    .WAIT_COUNTER_BITS (WAIT_COUNTER_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd),
    .half_period (half_period),
    .rsp_stall   (rsp_stall),
    .rsp_valid   (rsp_valid),
    .rsp         (rsp)
  );

endmodule

// ===== design/i2cw_checker.sv =====
// Port-level checks for the I2C master write engine, bound to the top level.
// Depends on i2cw_pkg for the structs and status codes.
module i2cw_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input i2cw_pkg::rsp_t rsp
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
  else $error("result changed while stalled");

  // Every accepted item gives a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> rsp_valid)
  else $error("accepted item produced no result");

  // No result appears without an accepted item.
  assert property (@(posedge clk) disable iff (rst)
    !(cmd_valid && !cmd_stall) && !(rsp_valid && rsp_stall) |=> !rsp_valid)
  else $error("result without a transfer");

  // The end of a STOP leaves the bus released and idle, with no ACK pulse.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.transfer_status != i2cw_pkg::STATUS_NONE) |->
      rsp.ready_res && rsp.scl_level && rsp.sda_drive && !rsp.byte_acked &&
      ((rsp.transfer_status == i2cw_pkg::STATUS_OK) ||
       (rsp.transfer_status == i2cw_pkg::STATUS_NACK)))
  else $error("bad status or bus levels at end of transfer");

endmodule

bind i2c_master_write_engine i2cw_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ===== test/tb_i2c_master_write_engine.sv =====
// Self-checking testbench for the I2C master write engine: a directed table, then random
// byte transfers under several half-period settings, each result checked against a predictor.
// Depends on i2cw_pkg and i2c_master_write_engine only.
`timescale 1ns / 1ps

module tb_i2c_master_write_engine;

  localparam int WAIT_BITS = i2cw_pkg::WAIT_COUNTER_BITS_DEFAULT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 3;
  localparam int REPORT_LIMIT = 10;
  localparam logic [i2cw_pkg::CFG_ADDR_BITS-1:0] HALF_PERIOD_ADDR =
    i2cw_pkg::CFG_ADDR_BITS'(4 * i2cw_pkg::REG_HALF_PERIOD);
  localparam logic [i2cw_pkg::CFG_ADDR_BITS-1:0] UNMAPPED_ADDR =
    i2cw_pkg::CFG_ADDR_BITS'(HALF_PERIOD_ADDR + 4);

  // Waveform phases of the engine, as the predictor tracks them.
  typedef enum logic [3:0] {
    BUS_IDLE, START_SETUP, START_HOLD, BIT_LOW, BIT_HIGH, ACK_LOW, ACK_HIGH,
    BYTE_HELD, STOP_SETUP, STOP_RISE, STOP_DONE
  } bus_phase_t;

  // Bus levels that can be read straight off the waveform.
  localparam i2cw_pkg::rsp_t R_IDLE      = '{1'b1, 1'b1, 1'b1, 1'b0, i2cw_pkg::STATUS_NONE};
  localparam i2cw_pkg::rsp_t R_START_A   = '{1'b1, 1'b1, 1'b0, 1'b0, i2cw_pkg::STATUS_NONE};
  localparam i2cw_pkg::rsp_t R_START_B   = '{1'b1, 1'b0, 1'b0, 1'b0, i2cw_pkg::STATUS_NONE};
  localparam i2cw_pkg::rsp_t R_LOW_ONE   = '{1'b0, 1'b1, 1'b0, 1'b0, i2cw_pkg::STATUS_NONE};
  localparam i2cw_pkg::rsp_t R_LOW_ZERO  = '{1'b0, 1'b0, 1'b0, 1'b0, i2cw_pkg::STATUS_NONE};
  localparam i2cw_pkg::rsp_t R_HELD_ACK  = '{1'b0, 1'b1, 1'b1, 1'b1, i2cw_pkg::STATUS_NONE};
  localparam i2cw_pkg::rsp_t R_ACK_STOP  = '{1'b0, 1'b0, 1'b0, 1'b1, i2cw_pkg::STATUS_NONE};
  localparam i2cw_pkg::rsp_t R_DONE_NACK = '{1'b1, 1'b1, 1'b1, 1'b0, i2cw_pkg::STATUS_NACK};
  localparam i2cw_pkg::rsp_t R_DONE_OK   = '{1'b1, 1'b1, 1'b1, 1'b0, i2cw_pkg::STATUS_OK};

  typedef struct packed {
    i2cw_pkg::cmd_t item;
    logic [7:0]     reps;
    logic           scramble;
    logic           typed;
    i2cw_pkg::rsp_t want;
  } step_row_t;

  // Directed walk at a half period of one tick, so every tick moves the waveform on.
  localparam int DIRECTED_ROWS = 24;
  localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b1}, 8'd1,  1'b1, 1'b1, R_IDLE},
    '{'{i2cw_pkg::CMD_LOAD, 8'h55, 1'b0, 1'b1, 1'b0}, 8'd1,  1'b0, 1'b1, R_IDLE},
    '{'{i2cw_pkg::CMD_LOAD, 8'hFF, 1'b1, 1'b0, 1'b1}, 8'd1,  1'b0, 1'b1, R_START_A},
    '{'{i2cw_pkg::CMD_LOAD, 8'h00, 1'b1, 1'b1, 1'b0}, 8'd1,  1'b0, 1'b1, R_START_A},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 8'd1,  1'b1, 1'b1, R_START_B},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 8'd1,  1'b1, 1'b1, R_LOW_ONE},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 8'd17, 1'b1, 1'b0, R_IDLE},
    '{'{i2cw_pkg::CMD_TICK, 8'hFF, 1'b1, 1'b1, 1'b0}, 8'd1,  1'b0, 1'b1, R_HELD_ACK},
    '{'{i2cw_pkg::CMD_LOAD, 8'h00, 1'b0, 1'b0, 1'b1}, 8'd1,  1'b0, 1'b1, R_LOW_ZERO},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 8'd17, 1'b1, 1'b0, R_IDLE},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 8'd1,  1'b0, 1'b1, R_HELD_ACK},
    '{'{i2cw_pkg::CMD_LOAD, 8'h80, 1'b1, 1'b1, 1'b0}, 8'd1,  1'b0, 1'b1, R_START_A},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 8'd19, 1'b1, 1'b0, R_IDLE},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b1}, 8'd1,  1'b0, 1'b1, R_LOW_ZERO},
    '{'{i2cw_pkg::CMD_LOAD, 8'h12, 1'b0, 1'b0, 1'b0}, 8'd1,  1'b0, 1'b1, R_LOW_ZERO},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 8'd2,  1'b1, 1'b0, R_IDLE},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 8'd1,  1'b1, 1'b1, R_DONE_NACK},
    '{'{i2cw_pkg::CMD_LOAD, 8'hFF, 1'b0, 1'b0, 1'b1}, 8'd1,  1'b0, 1'b1, R_IDLE},
    '{'{i2cw_pkg::CMD_LOAD, 8'h00, 1'b1, 1'b1, 1'b1}, 8'd1,  1'b0, 1'b1, R_START_A},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 8'd19, 1'b1, 1'b0, R_IDLE},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 8'd1,  1'b0, 1'b1, R_ACK_STOP},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 8'd2,  1'b1, 1'b0, R_IDLE},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 8'd1,  1'b1, 1'b1, R_DONE_OK},
    '{'{i2cw_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 8'd1,  1'b1, 1'b1, R_IDLE}
  };

  // Random phases: half period and number of items; the longest setting gets enough ticks
  // for the count to run out at least once.
  localparam int RUN_PHASES = 7;
  localparam logic [i2cw_pkg::HALF_PERIOD_BITS-1:0] PHASE_HALF [RUN_PHASES] =
    '{10'd24, 10'd0, 10'd1, 10'd2, 10'd1023, 10'd3, 10'd5};
  localparam int PHASE_ITEMS [RUN_PHASES] = '{150, 100, 150, 100, 1100, 100, 100};

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               cmd_valid = 1'b0;
  logic                               cmd_stall;
  i2cw_pkg::cmd_t                     cmd = '0;
  logic                               rsp_valid;
  logic                               rsp_stall = 1'b0;
  i2cw_pkg::rsp_t                     rsp;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [i2cw_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
  logic [i2cw_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
  logic [i2cw_pkg::CFG_DATA_BITS-1:0] prdata;
  logic                               pready;

  // Predicted engine state.
  bus_phase_t                            e_phase = BUS_IDLE;
  logic [3:0]                            e_bit = '0;
  logic [WAIT_BITS-1:0]                  e_wait = '0;
  logic [7:0]                            e_shift = '0;
  logic                                  e_stop = 1'b0;
  logic                                  e_abort = 1'b0;
  logic [i2cw_pkg::HALF_PERIOD_BITS-1:0] e_half = i2cw_pkg::HALF_PERIOD_RESET;

  i2cw_pkg::rsp_t bus_levels_due [$];
  i2cw_pkg::rsp_t oldest_due;
  int   mismatch_count = 0;
  int   burst_left = 0;
  int   items_sent = 0;
  int   bytes_acked = 0;
  int   clean_stops = 0;
  int   nack_stops = 0;

  i2c_master_write_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
  endtask

  // True when the next tick completes the current waveform phase.
  function automatic bit tick_ends_phase();
    logic [WAIT_BITS-1:0] lim;
    logic [WAIT_BITS-1:0] nxt;
    lim = WAIT_BITS'(e_half);
    if (lim == '0) begin
      lim = WAIT_BITS'(1);
    end
    nxt = e_wait + 1'b1;
    return (nxt == '0) || (nxt >= lim);
  endfunction

  function automatic i2cw_pkg::rsp_t predict_bus_levels(input i2cw_pkg::cmd_t it);
    i2cw_pkg::rsp_t r;
    bit             ends;
    r = '0;
    r.transfer_status = i2cw_pkg::STATUS_NONE;
    if (it.command == i2cw_pkg::CMD_LOAD) begin
      // Loads only land on an idle or held bus; a follow-on byte needs an open transfer.
      if ((e_phase == BUS_IDLE || e_phase == BYTE_HELD) &&
          (it.first_byte || (e_phase == BYTE_HELD && !e_abort))) begin
        e_shift = it.data_byte;
        e_stop = it.last_byte;
        e_bit = '0;
        e_wait = '0;
        if (it.first_byte) begin
          e_abort = 1'b0;
          e_phase = START_SETUP;
        end else begin
          e_phase = BIT_LOW;
        end
      end
    end else if (e_phase != BUS_IDLE && e_phase != BYTE_HELD) begin
      ends = tick_ends_phase();
      e_wait = e_wait + 1'b1;
      if (ends) begin
        e_wait = '0;
        case (e_phase)
          START_SETUP: e_phase = START_HOLD;
          START_HOLD:  e_phase = BIT_LOW;
          BIT_LOW:     e_phase = BIT_HIGH;
          BIT_HIGH: begin
            e_shift = e_shift << 1;
            if (e_bit < 4'd7) begin
              e_bit = e_bit + 1'b1;
              e_phase = BIT_LOW;
            end else begin
              e_bit = 4'd8;
              e_phase = ACK_LOW;
            end
          end
          ACK_LOW: e_phase = ACK_HIGH;
          ACK_HIGH: begin
            e_bit = '0;
            if (!it.sda_level) begin
              r.byte_acked = 1'b1;
              e_phase = e_stop ? STOP_SETUP : BYTE_HELD;
            end else begin
              e_abort = 1'b1;
              e_phase = STOP_SETUP;
            end
          end
          STOP_SETUP: e_phase = STOP_RISE;
          STOP_RISE:  e_phase = STOP_DONE;
          default: begin
            r.transfer_status = e_abort ? i2cw_pkg::STATUS_NACK : i2cw_pkg::STATUS_OK;
            e_stop = 1'b0;
            e_phase = BUS_IDLE;
          end
        endcase
      end
    end
    case (e_phase)
      START_HOLD:         {r.scl_level, r.sda_drive} = 2'b10;
      BIT_LOW:            {r.scl_level, r.sda_drive} = {1'b0, e_shift[7]};
      BIT_HIGH:           {r.scl_level, r.sda_drive} = {1'b1, e_shift[7]};
      ACK_LOW, BYTE_HELD: {r.scl_level, r.sda_drive} = 2'b01;
      STOP_SETUP:         {r.scl_level, r.sda_drive} = 2'b00;
      STOP_RISE:          {r.scl_level, r.sda_drive} = 2'b10;
      default:            {r.scl_level, r.sda_drive} = 2'b11;
    endcase
    r.ready_res = (e_phase == BUS_IDLE || e_phase == BYTE_HELD);
    return r;
  endfunction

  // Mostly well-formed transfers: address byte when idle, data or repeated START when
  // held, ticks while busy, with a mostly-ACKing slave and some stray loads.
  function automatic i2cw_pkg::cmd_t random_item();
    i2cw_pkg::cmd_t it;
    int unsigned    roll;
    it.command = i2cw_pkg::CMD_TICK;
    it.data_byte = 8'($urandom);
    it.first_byte = 1'($urandom);
    it.last_byte = 1'($urandom);
    it.sda_level = 1'($urandom);
    roll = $urandom_range(0, 99);
    case (e_phase)
      BUS_IDLE: begin
        if (roll < 85) begin
          it.command = i2cw_pkg::CMD_LOAD;
          it.first_byte = 1'b1;
          it.last_byte = ($urandom_range(0, 2) == 0);
        end else if (roll < 92) begin
          it.command = i2cw_pkg::CMD_LOAD;
          it.first_byte = 1'b0;
        end
      end
      BYTE_HELD: begin
        if (roll < 70) begin
          it.command = i2cw_pkg::CMD_LOAD;
          it.first_byte = 1'b0;
          it.last_byte = ($urandom_range(0, 2) == 0);
        end else if (roll < 85) begin
          it.command = i2cw_pkg::CMD_LOAD;
          it.first_byte = 1'b1;
        end
      end
      default: begin
        if (roll < 4) begin
          it.command = i2cw_pkg::CMD_LOAD;
        end else if (e_phase == ACK_HIGH && tick_ends_phase()) begin
          it.sda_level = ($urandom_range(0, 99) < 15);
        end
      end
    endcase
    return it;
  endfunction

  task automatic send_item(input i2cw_pkg::cmd_t it, input bit typed,
                           input i2cw_pkg::rsp_t want);
    i2cw_pkg::rsp_t got;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 80);
      if ($urandom_range(0, 24) == 0) begin
        // Hold off until the engine has handed back every result.
        cmd_valid <= 1'b0;
        do @(posedge clk); while (bus_levels_due.size() != 0);
      end else if ($urandom_range(0, 9) < 6) begin
        cmd_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    cmd <= it;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    burst_left--;
    items_sent++;
    got = predict_bus_levels(it);
    bus_levels_due.push_back(typed ? want : got);
    if (got.byte_acked) begin
      bytes_acked++;
    end
    if (got.transfer_status == i2cw_pkg::STATUS_OK) begin
      clean_stops++;
    end else if (got.transfer_status == i2cw_pkg::STATUS_NACK) begin
      nack_stops++;
    end
  endtask

  task automatic apb_write(input logic [i2cw_pkg::CFG_ADDR_BITS-1:0] addr,
                           input logic [i2cw_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [i2cw_pkg::CFG_ADDR_BITS-1:0] addr,
                          output logic [i2cw_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits for the engine to go quiet, then programs the half period. A write just past
  // the register map must leave it untouched, which the read-back confirms.
  task automatic set_half_period(input logic [i2cw_pkg::HALF_PERIOD_BITS-1:0] value);
    logic [i2cw_pkg::CFG_DATA_BITS-1:0] word;
    logic [i2cw_pkg::CFG_DATA_BITS-1:0] back;
    cmd_valid <= 1'b0;
    do @(posedge clk); while (bus_levels_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    word = $urandom;
    word[i2cw_pkg::HALF_PERIOD_BITS-1:0] = value;
    apb_write(HALF_PERIOD_ADDR, word);
    e_half = value;
    apb_write(UNMAPPED_ADDR, $urandom);
    apb_read(HALF_PERIOD_ADDR, back);
    if (back !== i2cw_pkg::CFG_DATA_BITS'(value)) begin
      note_mismatch($sformatf("half period read back %0d, expected %0d", back, value));
    end
  endtask

  initial begin : stall_pattern
    int unsigned mode;
    int unsigned span;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       rsp_stall <= 1'b0;
          1:       rsp_stall <= ($urandom_range(0, 3) == 0);
          default: rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      if (bus_levels_due.size() == 0) begin
        note_mismatch($sformatf("result %p with nothing outstanding", rsp));
      end else begin
        oldest_due = bus_levels_due.pop_front();
        if (rsp.scl_level !== oldest_due.scl_level ||
            rsp.sda_drive !== oldest_due.sda_drive ||
            rsp.ready_res !== oldest_due.ready_res ||
            rsp.byte_acked !== oldest_due.byte_acked ||
            rsp.transfer_status !== oldest_due.transfer_status) begin
          note_mismatch($sformatf(
            "scl/sda/ready/ack/status expected %b/%b/%b/%b/%0d got %b/%b/%b/%b/%0d",
            oldest_due.scl_level, oldest_due.sda_drive, oldest_due.ready_res,
            oldest_due.byte_acked, oldest_due.transfer_status, rsp.scl_level,
            rsp.sda_drive, rsp.ready_res, rsp.byte_acked, rsp.transfer_status));
        end
      end
    end
  end

  // Ends the run if neither channel completes a transfer for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && cmd_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_i2c_master_write_engine: done, errors");
    $finish;
  end

  initial begin : stimulus
    i2cw_pkg::cmd_t                     it;
    logic [i2cw_pkg::CFG_DATA_BITS-1:0] back;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    apb_read(HALF_PERIOD_ADDR, back);
    if (back !== i2cw_pkg::CFG_DATA_BITS'(i2cw_pkg::HALF_PERIOD_RESET)) begin
      note_mismatch($sformatf("half period after reset %0d, expected %0d",
                              back, i2cw_pkg::HALF_PERIOD_RESET));
    end

    set_half_period(10'd1);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      for (int k = 0; k < DIRECTED[i].reps; k++) begin
        it = DIRECTED[i].item;
        if (DIRECTED[i].scramble) begin
          it.data_byte = 8'($urandom);
          it.first_byte = 1'($urandom);
          it.last_byte = 1'($urandom);
          it.sda_level = 1'($urandom);
        end
        send_item(it, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (int p = 0; p < RUN_PHASES; p++) begin
      set_half_period(PHASE_HALF[p]);
      repeat (PHASE_ITEMS[p]) send_item(random_item(), 1'b0, R_IDLE);
    end

    cmd_valid <= 1'b0;
    do @(posedge clk); while (bus_levels_due.size() != 0);
    repeat (SETTLE_CYCLES + 1) @(posedge clk);
    if (bus_levels_due.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", bus_levels_due.size()));
    end

    $display("Sent %0d items over %0d half-period settings: %0d bytes acknowledged,",
             items_sent, RUN_PHASES + 1, bytes_acked);
    $display("%0d transfers closed cleanly, %0d aborted on NACK, %0d mismatches.",
             clean_stops, nack_stops, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_i2c_master_write_engine: done, clean");
    end else begin
      $display("tb_i2c_master_write_engine: done, errors");
    end
    $finish;
  end

endmodule

// ===== i2c_master_write_engine.f =====
design/i2cw_pkg.sv
design/i2cw_regs.sv
design/i2cw_engine.sv
design/i2c_master_write_engine.sv
design/i2cw_checker.sv
test/tb_i2c_master_write_engine.sv
